[design/gpsg_pkg.sv]
// ----------------------------------------------------------------------------
// gpsg_pkg
// Types and constants shared by the grid page scan generator.
// ----------------------------------------------------------------------------
package gpsg_pkg;

    localparam int NUM_W  = 36;
    localparam int DEN_W  = 32;
    localparam int CNT_W  = 6;
    localparam int WIN_W  = 34;
    localparam int IDX_W  = 3;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_HOLD   = 2'd1;
    localparam logic [1:0] ACT_LOCATE = 2'd2;

    localparam logic [1:0] MODE_XY = 2'd1;
    localparam logic [1:0] MODE_ZY = 2'd2;

    localparam logic [IDX_W-1:0] REG_AXIS_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_ORIGIN_X   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y   = 3'd2;
    localparam logic [IDX_W-1:0] REG_CELL_SIZE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LOAD_RAD   = 3'd4;
    localparam logic [IDX_W-1:0] REG_HOLD_RAD   = 3'd5;
    localparam logic [IDX_W-1:0] REG_RANGE_X    = 3'd6;
    localparam logic [IDX_W-1:0] REG_RANGE_Y    = 3'd7;

    typedef struct packed {
        logic take_in;
        logic div_start;
        logic div_sel_y;
        logic cap_cx;
        logic cap_cy;
        logic win_load;
        logic emit_scan;
        logic emit_loc;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic op_scan;
        logic win_empty;
        logic scan_last;
        logic out_free;
    } sts_t;

endpackage

[design/gpsg_ifs.sv]
// ----------------------------------------------------------------------------
// gpsg interfaces
// Valid/ready channels for input items, result beats and register writes.
// ----------------------------------------------------------------------------
interface gpsg_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    modport source (output valid, op, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, op, pos_x, pos_y, pos_z, output ready);
endinterface

interface gpsg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] page_id;
    logic [1:0]  action;
    logic        last_of_run;
    modport source (output valid, page_id, action, last_of_run, input ready);
    modport sink   (input valid, page_id, action, last_of_run, output ready);
endinterface

interface gpsg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/gpsg_div.sv]
// ----------------------------------------------------------------------------
// gpsg_div
// Bit-serial floor divider, one quotient bit per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module gpsg_div
    import gpsg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [31:0]      quot
);
    localparam logic signed [NUM_W+1:0] Q_MAX = 38'sd2147483647;
    localparam logic signed [NUM_W+1:0] Q_MIN = -38'sd2147483648;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_W-1:0]     dvd_reg, dvd_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DEN_W:0]       rem_sh, trial;
    logic signed [NUM_W+1:0] qs;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg, dvd_reg[NUM_W-1]};
        trial     = rem_sh - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[NUM_W-1];
            dvd_next  = num[NUM_W-1] ? (~num + 1'b1) : num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_next = trial[DEN_W-1:0];
                dvd_next = {dvd_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DEN_W-1:0];
                dvd_next = {dvd_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (neg_reg)
            qs = -$signed({2'b00, dvd_reg}) - $signed({{(NUM_W+1){1'b0}}, (rem_reg != '0)});
        else
            qs = $signed({2'b00, dvd_reg});
        if (qs > Q_MAX)
            quot = 32'sh7FFFFFFF;
        else if (qs < Q_MIN)
            quot = 32'sh80000000;
        else
            quot = qs[31:0];
    end

    assign done = done_reg;

endmodule

[design/gpsg_ctrl.sv]
// ----------------------------------------------------------------------------
// gpsg_ctrl
// Sequencer: two divides, then window set-up and the scan, or the locate beat.
// ----------------------------------------------------------------------------
module gpsg_ctrl
    import gpsg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_STX  = 3'd1;
    localparam logic [2:0] S_WX   = 3'd2;
    localparam logic [2:0] S_STY  = 3'd3;
    localparam logic [2:0] S_WY   = 3'd4;
    localparam logic [2:0] S_WIN  = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_STX;
                end
            end
            S_STX:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WX;
            end
            S_WX:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_cx = 1'b1;
                    state_next = S_STY;
                end
            end
            S_STY:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel_y = 1'b1;
                state_next    = S_WY;
            end
            S_WY:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_cy = 1'b1;
                    state_next = sts.op_scan ? S_WIN : S_OUT;
                end
            end
            S_WIN:
            begin
                cmd.win_load = 1'b1;
                state_next   = S_CHK;
            end
            S_CHK:
            begin
                if (sts.win_empty)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.emit_scan = 1'b1;
                    if (sts.scan_last)
                        state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_loc = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[design/gpsg_dp.sv]
// ----------------------------------------------------------------------------
// gpsg_dp
// Registers, projection, divider, window bounds, scan counters, output beat.
// ----------------------------------------------------------------------------
module gpsg_dp
    import gpsg_pkg::*;
#(
    parameter int MAX_HOLD_CELLS = 3,
    parameter int FRAC_BITS      = 8
)
(
    input  logic clk,
    input  logic rst_n,
    gpsg_in_if.sink    in_ch,
    gpsg_out_if.source out_ch,
    gpsg_cfg_if.sink   cfg,
    input  cmd_t cmd,
    output sts_t sts
);
    localparam logic [31:0] ROUND  = 32'((1 << FRAC_BITS) - 1);
    localparam logic [31:0] HR_MAX = 32'(MAX_HOLD_CELLS << FRAC_BITS);

    logic [1:0]         axis_mode_reg;
    logic signed [31:0] origin_x_reg, origin_y_reg;
    logic [30:0]        cell_size_reg;
    logic [9:0]         load_rad_reg, hold_rad_reg;
    logic [31:0]        range_x_reg, range_y_reg;

    logic               op_reg;
    logic signed [32:0] gx_reg, gy_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [WIN_W-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic signed [WIN_W-1:0] lxmin_reg, lxmax_reg, lymin_reg, lymax_reg;
    logic signed [WIN_W-1:0] x_reg, y_reg;
    logic               empty_reg;

    logic               ov_reg, ov_next;
    logic [31:0]        pid_reg;
    logic [1:0]         act_reg;
    logic               last_reg;

    logic signed [32:0] pos_x_e, pos_y_e, neg_z;
    logic [30:0]        cs;
    logic signed [32:0] g_sel;
    logic signed [31:0] org_sel;
    logic signed [WIN_W-1:0] diff;
    logic signed [NUM_W-1:0] num;
    logic               div_done;
    logic signed [31:0] quot;

    logic [31:0]        hr_sat, h_w, l_w;
    logic signed [WIN_W-1:0] h_s, l_s, cx_s, cy_s;
    logic signed [WIN_W-1:0] rxmin, rxmax, rymin, rymax;
    logic signed [WIN_W-1:0] xmin_c, xmax_c, ymin_c, ymax_c, t;
    logic signed [WIN_W-1:0] lxmin_c, lxmax_c, lymin_c, lymax_c;
    logic               in_load, x_end;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_mode_reg <= 2'd0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            cell_size_reg <= 31'd256000;
            load_rad_reg  <= 10'd512;
            hold_rad_reg  <= 10'd768;
            range_x_reg   <= 32'h7FFF8000;
            range_y_reg   <= 32'h7FFF8000;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_AXIS_MODE: axis_mode_reg <= cfg.data[1:0];
                REG_ORIGIN_X:  origin_x_reg  <= cfg.data;
                REG_ORIGIN_Y:  origin_y_reg  <= cfg.data;
                REG_CELL_SIZE: cell_size_reg <= cfg.data[30:0];
                REG_LOAD_RAD:  load_rad_reg  <= cfg.data[9:0];
                REG_HOLD_RAD:  hold_rad_reg  <= cfg.data[9:0];
                REG_RANGE_X:   range_x_reg   <= cfg.data;
                REG_RANGE_Y:   range_y_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    assign pos_x_e = {in_ch.pos_x[31], in_ch.pos_x};
    assign pos_y_e = {in_ch.pos_y[31], in_ch.pos_y};
    assign neg_z   = -$signed({in_ch.pos_z[31], in_ch.pos_z});
    assign cs      = (cell_size_reg == '0) ? 31'd1 : cell_size_reg;

    assign g_sel   = cmd.div_sel_y ? gy_reg : gx_reg;
    assign org_sel = cmd.div_sel_y ? origin_y_reg : origin_x_reg;
    assign diff    = {g_sel[32], g_sel} - {{2{org_sel[31]}}, org_sel};
    assign num     = {diff[WIN_W-1], diff, 1'b0} + $signed({5'b0, cs});

    gpsg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   ({cs, 1'b0}),
        .done  (div_done),
        .quot  (quot)
    );

    always_comb
    begin
        hr_sat  = ({22'b0, hold_rad_reg} > HR_MAX) ? HR_MAX : {22'b0, hold_rad_reg};
        h_w     = (hr_sat + ROUND) >> FRAC_BITS;
        l_w     = ({22'b0, load_rad_reg} + ROUND) >> FRAC_BITS;
        h_s     = $signed({{(WIN_W-11){1'b0}}, h_w[10:0]});
        l_s     = $signed({{(WIN_W-11){1'b0}}, l_w[10:0]});
        cx_s    = {{2{cx_reg[31]}}, cx_reg};
        cy_s    = {{2{cy_reg[31]}}, cy_reg};
        rxmin   = {{18{range_x_reg[15]}}, range_x_reg[15:0]};
        rxmax   = {{18{range_x_reg[31]}}, range_x_reg[31:16]};
        rymin   = {{18{range_y_reg[15]}}, range_y_reg[15:0]};
        rymax   = {{18{range_y_reg[31]}}, range_y_reg[31:16]};
        t       = cx_s - h_s;
        xmin_c  = (t < rxmin) ? rxmin : t;
        t       = cx_s + h_s;
        xmax_c  = (t > rxmax) ? rxmax : t;
        t       = cy_s - h_s;
        ymin_c  = (t < rymin) ? rymin : t;
        t       = cy_s + h_s;
        ymax_c  = (t > rymax) ? rymax : t;
        t       = cx_s - l_s;
        lxmin_c = (t < xmin_c) ? xmin_c : t;
        t       = cx_s + l_s;
        lxmax_c = (t > xmax_c) ? xmax_c : t;
        t       = cy_s - l_s;
        lymin_c = (t < ymin_c) ? ymin_c : t;
        t       = cy_s + l_s;
        lymax_c = (t > ymax_c) ? ymax_c : t;
    end

    assign in_load = (x_reg >= lxmin_reg) && (x_reg <= lxmax_reg)
                  && (y_reg >= lymin_reg) && (y_reg <= lymax_reg);
    assign x_end   = (x_reg == xmax_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            op_reg <= in_ch.op;
            gx_reg <= (axis_mode_reg == MODE_ZY) ? neg_z : pos_x_e;
            gy_reg <= (axis_mode_reg == MODE_XY || axis_mode_reg == MODE_ZY) ? pos_y_e : neg_z;
        end
        if (cmd.cap_cx)
            cx_reg <= quot;
        if (cmd.cap_cy)
            cy_reg <= quot;
        if (cmd.win_load)
        begin
            xmin_reg  <= xmin_c;
            xmax_reg  <= xmax_c;
            ymin_reg  <= ymin_c;
            ymax_reg  <= ymax_c;
            lxmin_reg <= lxmin_c;
            lxmax_reg <= lxmax_c;
            lymin_reg <= lymin_c;
            lymax_reg <= lymax_c;
            x_reg     <= xmin_c;
            y_reg     <= ymin_c;
            empty_reg <= (xmin_c > xmax_c) || (ymin_c > ymax_c);
        end
        else if (cmd.emit_scan)
        begin
            if (x_end)
            begin
                x_reg <= xmin_reg;
                y_reg <= y_reg + 1'b1;
            end
            else
                x_reg <= x_reg + 1'b1;
        end
        if (cmd.emit_scan)
        begin
            pid_reg  <= {x_reg[15:0], y_reg[15:0]};
            act_reg  <= in_load ? ACT_LOAD : ACT_HOLD;
            last_reg <= x_end && (y_reg == ymax_reg);
        end
        else if (cmd.emit_loc)
        begin
            pid_reg  <= {cx_reg[15:0], cy_reg[15:0]};
            act_reg  <= ACT_LOCATE;
            last_reg <= 1'b1;
        end
    end

    assign ov_next = (cmd.emit_scan || cmd.emit_loc) ? 1'b1 : (out_ch.ready ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= ov_next;
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.page_id     = pid_reg;
    assign out_ch.action      = act_reg;
    assign out_ch.last_of_run = last_reg;

    assign sts.div_done  = div_done;
    assign sts.op_scan   = op_reg;
    assign sts.win_empty = empty_reg;
    assign sts.scan_last = x_end && (y_reg == ymax_reg);
    assign sts.out_free  = !ov_reg || out_ch.ready;

endmodule

[design/grid_page_scan_generator.sv]
// ----------------------------------------------------------------------------
// grid_page_scan_generator
// Projects a position to a grid cell and emits its page ID or hold window scan.
// ----------------------------------------------------------------------------
// Operation: two serial divides, one per axis; then the located page, or window
// set-up and the hold window scan, one result beat a cycle while the sink is
// ready.
// Throughput: one item at a time; the next input beat is taken after the locate
// beat, after a scan of N results (N <= 49 by default), or after an empty window.
// Reset: asynchronous, active low; control and configuration registers return to their defaults.
module grid_page_scan_generator
    import gpsg_pkg::*;
#(
    parameter int MAX_HOLD_CELLS = 3,
    parameter int FRAC_BITS      = 8
)
(
    input  logic clk,
    input  logic rst_n,
    gpsg_in_if.sink    in_ch,
    gpsg_out_if.source out_ch,
    gpsg_cfg_if.sink   cfg
);
    cmd_t cmd;
    sts_t sts;

    gpsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gpsg_dp #(
        .MAX_HOLD_CELLS (MAX_HOLD_CELLS),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule

[design/gpsg_checker.sv]
// ----------------------------------------------------------------------------
// gpsg_checker
// Port-level checks on the grid page scan generator.
// ----------------------------------------------------------------------------
module gpsg_checker
    import gpsg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] page_id,
    input logic [1:0]  action,
    input logic        last_of_run
);
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_locate_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_LOCATE |-> last_of_run)
        else $error("locate beat without last flag");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(page_id) && $stable(action)
                                    && $stable(last_of_run))
        else $error("stalled beat changed");

endmodule

bind grid_page_scan_generator gpsg_checker u_gpsg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .page_id     (out_ch.page_id),
    .action      (out_ch.action),
    .last_of_run (out_ch.last_of_run)
);
